// ===== rtl/core/mandelbrot_escape_time_macros.svh =====
// ============================================================================
// Mandelbrot escape-time assertion macros
// Concurrent assertion shorthands on clk and arst_n; empty under synthesis.
// ============================================================================
`ifndef MANDELBROT_ESCAPE_TIME_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define MBROT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define MBROT_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MBROT_ASSERT_IMP(label, ante, cons, msg)
`define MBROT_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/core/mbrot_pkg.sv =====
// ============================================================================
// Mandelbrot escape-time package
// Shared widths, register map, job and result types, sequencer states and
// the saturation helpers of the Q8.56 datapath.
// ============================================================================
`default_nettype none

package mbrot_pkg;

	localparam int unsigned MAX_SIDE    = 4096;
	localparam int unsigned FRAC_BITS   = 56;
	localparam int unsigned COORD_W     = 64;
	localparam int unsigned PROD_W      = 2 * COORD_W;
	localparam int unsigned PIX_W       = 12;
	localparam int unsigned SIDE_W      = 13;
	localparam int unsigned ITER_W      = 16;
	localparam int unsigned INDEX_W     = 24;
	localparam int unsigned ADDR_W      = 6;
	localparam int unsigned REG_LSB     = 3;
	localparam int unsigned REG_IDX_W   = ADDR_W - REG_LSB;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [SIDE_W-1:0] MAX_SIDE_V = SIDE_W'(MAX_SIDE);

	// |z|^2 escape bound: 4.0 at 2*FRAC_BITS fraction bits
	localparam logic [PROD_W-1:0] ESC_THRESH = PROD_W'(1) << (2 * FRAC_BITS + 2);

	// register indexes (byte address / 8)
	localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_STEP_X   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_STEP_Y   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_WIDTH    = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_HEIGHT   = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_MAX_ITER = 3'd6;

	localparam logic [COORD_W-1:0] ORIGIN_RST   = '0;
	localparam logic [COORD_W-1:0] STEP_RST     = '0;
	localparam logic [SIDE_W-1:0]  SIDE_RST     = 13'd1024;
	localparam logic [ITER_W-1:0]  MAX_ITER_RST = 16'd256;

	typedef struct packed {
		logic [COORD_W-1:0] origin_x;
		logic [COORD_W-1:0] origin_y;
		logic [COORD_W-1:0] step_x;
		logic [COORD_W-1:0] step_y;
		logic [SIDE_W-1:0]  width;
		logic [SIDE_W-1:0]  height;
		logic [ITER_W-1:0]  max_iter;
	} cfg_t;

	typedef struct packed {
		logic [PIX_W-1:0]   px;
		logic [PIX_W-1:0]   py;
		logic [INDEX_W-1:0] idx;
	} job_t;

	typedef struct packed {
		logic [ITER_W-1:0]  count;
		logic [INDEX_W-1:0] index;
	} res_t;

	typedef enum logic [2:0] {
		MP_IDLE,
		MP_LL,
		MP_LH,
		MP_HL,
		MP_HH,
		MP_LAST,
		MP_SIGN
	} mul_state_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MAP,
		BK_MAP_WAIT,
		BK_LOOP,
		BK_SQ_WAIT,
		BK_SUM,
		BK_UPD,
		BK_EMIT
	} back_state_t;

	function automatic logic [PROD_W-1:0] sext128(input logic [COORD_W-1:0] v);
		return {{COORD_W{v[COORD_W-1]}}, v};
	endfunction

	// clamp a wide two's complement value to the signed 64-bit range
	function automatic logic [COORD_W-1:0] sat64(input logic [PROD_W-1:0] v);
		logic all_ones;
		logic all_zeros;
		all_ones  = &v[PROD_W-1:COORD_W-1];
		all_zeros = ~|v[PROD_W-1:COORD_W-1];
		if (all_ones || all_zeros) begin
			return v[COORD_W-1:0];
		end else if (v[PROD_W-1]) begin
			return {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			return {1'b0, {(COORD_W-1){1'b1}}};
		end
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mbrot_front.sv =====
// ============================================================================
// Mandelbrot front end
// Takes pixel transfers, drops pixels outside the region and pushes in-range
// pixels with their row-major index into the job queue.
// ============================================================================
`default_nettype none

module mbrot_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       pix_valid,
	output logic                       pix_stall,
	input  logic [mbrot_pkg::PIX_W-1:0] pixel_x,
	input  logic [mbrot_pkg::PIX_W-1:0] pixel_y,
	input  mbrot_pkg::cfg_t            cfg,
	input  logic                       q_full,
	output logic                       push,
	output mbrot_pkg::job_t            job
);
	import mbrot_pkg::*;

	logic                     valid_s1;
	logic [PIX_W-1:0]         px_s1;
	logic [PIX_W-1:0]         py_s1;
	logic [SIDE_W-1:0]        w_eff;
	logic [SIDE_W-1:0]        h_eff;
	logic                     in_range;
	logic                     advance;
	logic                     take;
	logic [PIX_W+SIDE_W-1:0]  idx_full;

	// oversized sides count as MAX_SIDE
	assign w_eff = (cfg.width > MAX_SIDE_V) ? MAX_SIDE_V : cfg.width;
	assign h_eff = (cfg.height > MAX_SIDE_V) ? MAX_SIDE_V : cfg.height;

	assign in_range = (SIDE_W'(px_s1) < w_eff) && (SIDE_W'(py_s1) < h_eff);
	assign idx_full = (PIX_W+SIDE_W)'(py_s1) * (PIX_W+SIDE_W)'(w_eff)
		+ (PIX_W+SIDE_W)'(px_s1);

	// drop out-of-range pixels at once, hold in-range ones until the queue has room
	assign advance   = valid_s1 && (!in_range || !q_full);
	assign push      = valid_s1 && in_range && !q_full;
	assign pix_stall = valid_s1 && !advance;
	assign take      = pix_valid && !pix_stall;

	assign job.px  = px_s1;
	assign job.py  = py_s1;
	assign job.idx = idx_full[INDEX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			px_s1 <= pixel_x;
			py_s1 <= pixel_y;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/mbrot_queue.sv =====
// ============================================================================
// Mandelbrot job queue
// Short FIFO of pixel jobs between the front end and the iteration engine.
// ============================================================================
`default_nettype none

module mbrot_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  mbrot_pkg::job_t push_data,
	output logic            full,
	input  logic            pop,
	output mbrot_pkg::job_t pop_data,
	output logic            avail
);
	import mbrot_pkg::*;

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

	job_t              mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign avail    = (count_q != '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/mbrot_mul64.sv =====
// ============================================================================
// Mandelbrot 64x64 multiplier
// Exact signed 64x64 -> 128 product from four 32x32 partial products on one
// multiplier, sign applied at the end.
// ============================================================================
`default_nettype none

module mbrot_mul64 (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [mbrot_pkg::COORD_W-1:0] a,
	input  logic [mbrot_pkg::COORD_W-1:0] b,
	output logic                          done,
	output logic [mbrot_pkg::PROD_W-1:0]  prod
);
	import mbrot_pkg::*;

	localparam int unsigned HALF_W = COORD_W / 2;

	mul_state_t          state_q;
	mul_state_t          state_n;
	logic [COORD_W-1:0]  ua_q;
	logic [COORD_W-1:0]  ub_q;
	logic                neg_q;
	logic [COORD_W-1:0]  part_q;
	logic [PROD_W-1:0]   acc_q;
	logic [PROD_W-1:0]   prod_q;
	logic                done_q;
	logic [HALF_W-1:0]   op_a;
	logic [HALF_W-1:0]   op_b;
	logic [PROD_W-1:0]   term;

	assign done = done_q;
	assign prod = prod_q;

	// partial product selection and the shifted term that joins the sum
	always_comb begin
		state_n = state_q;
		op_a    = ua_q[HALF_W-1:0];
		op_b    = ub_q[HALF_W-1:0];
		term    = '0;
		unique case (state_q)
			MP_IDLE: begin
				if (start) begin
					state_n = MP_LL;
				end
			end
			MP_LL: begin
				state_n = MP_LH;
			end
			MP_LH: begin
				op_b    = ub_q[COORD_W-1:HALF_W];
				term    = PROD_W'(part_q);
				state_n = MP_HL;
			end
			MP_HL: begin
				op_a    = ua_q[COORD_W-1:HALF_W];
				term    = PROD_W'(part_q) << HALF_W;
				state_n = MP_HH;
			end
			MP_HH: begin
				op_a    = ua_q[COORD_W-1:HALF_W];
				op_b    = ub_q[COORD_W-1:HALF_W];
				term    = PROD_W'(part_q) << HALF_W;
				state_n = MP_LAST;
			end
			MP_LAST: begin
				term    = PROD_W'(part_q) << COORD_W;
				state_n = MP_SIGN;
			end
			MP_SIGN: begin
				state_n = MP_IDLE;
			end
			default: begin
				state_n = MP_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MP_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			done_q  <= (state_q == MP_SIGN);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == MP_IDLE) begin
			if (start) begin
				ua_q  <= a[COORD_W-1] ? (~a + 1'b1) : a;
				ub_q  <= b[COORD_W-1] ? (~b + 1'b1) : b;
				neg_q <= a[COORD_W-1] ^ b[COORD_W-1];
				acc_q <= '0;
			end
		end else begin
			part_q <= COORD_W'(op_a) * COORD_W'(op_b);
			acc_q  <= acc_q + term;
		end
		if (state_q == MP_SIGN) begin
			prod_q <= neg_q ? (~acc_q + 1'b1) : acc_q;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/mbrot_back.sv =====
// ============================================================================
// Mandelbrot iteration engine
// Pops a job, maps the pixel to c, iterates z = z^2 + c on three multipliers,
// two of them shared with the mapping, and hands the count to the output register.
// ============================================================================
`default_nettype none

module mbrot_back (
	input  logic            clk,
	input  logic            arst_n,
	input  mbrot_pkg::cfg_t cfg,
	input  mbrot_pkg::job_t job,
	input  logic            job_avail,
	output logic            job_pop,
	input  logic            slot_free,
	output logic            emit,
	output mbrot_pkg::res_t res
);
	import mbrot_pkg::*;

	back_state_t         state_q;
	back_state_t         state_n;
	job_t                job_q;
	logic [COORD_W-1:0]  cr_q;
	logic [COORD_W-1:0]  ci_q;
	logic [COORD_W-1:0]  zr_q;
	logic [COORD_W-1:0]  zi_q;
	logic [ITER_W-1:0]   iter_q;
	logic [PROD_W-1:0]   mag_q;
	logic signed [PROD_W-1:0] diff_q;

	logic                map_sel;
	logic                start_ab;
	logic                start_c;
	logic [COORD_W-1:0]  a_op_a;
	logic [COORD_W-1:0]  a_op_b;
	logic [COORD_W-1:0]  b_op_a;
	logic [COORD_W-1:0]  b_op_b;
	logic [PROD_W-1:0]   pa;
	logic [PROD_W-1:0]   pb;
	logic [PROD_W-1:0]   pc;
	logic                done_a;
	logic                done_b;
	logic                done_c;
	logic                map_done;
	logic                sq_done;
	logic                escape;
	logic [COORD_W-1:0]  cr_n;
	logic [COORD_W-1:0]  ci_n;
	logic [COORD_W-1:0]  zr_n;
	logic [COORD_W-1:0]  zi_n;
	logic signed [PROD_W-1:0] diff_sh;
	logic signed [PROD_W-1:0] cross_sh;

	// unit A: px*step_x, then zr^2; unit B: py*step_y, then zi^2; unit C: zr*zi
	assign map_sel = (state_q == BK_MAP);
	assign a_op_a  = map_sel ? COORD_W'(job_q.px) : zr_q;
	assign a_op_b  = map_sel ? cfg.step_x : zr_q;
	assign b_op_a  = map_sel ? COORD_W'(job_q.py) : zi_q;
	assign b_op_b  = map_sel ? cfg.step_y : zi_q;

	mbrot_mul64 u_mul_a (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_ab),
		.a      (a_op_a),
		.b      (a_op_b),
		.done   (done_a),
		.prod   (pa)
	);

	mbrot_mul64 u_mul_b (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_ab),
		.a      (b_op_a),
		.b      (b_op_b),
		.done   (done_b),
		.prod   (pb)
	);

	mbrot_mul64 u_mul_c (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_c),
		.a      (zr_q),
		.b      (zi_q),
		.done   (done_c),
		.prod   (pc)
	);

	assign map_done = done_a && done_b;
	assign sq_done  = done_a && done_b && done_c;
	assign escape   = (mag_q >= ESC_THRESH);

	assign cr_n = sat64(sext128(cfg.origin_x) + pa);
	assign ci_n = sat64(sext128(cfg.origin_y) - pb);

	// rescale: real part by FRAC_BITS, doubled cross term by one less
	assign diff_sh  = diff_q >>> FRAC_BITS;
	assign cross_sh = $signed(pc) >>> (FRAC_BITS - 1);
	assign zr_n     = sat64(diff_sh + sext128(cr_q));
	assign zi_n     = sat64(cross_sh + sext128(ci_q));

	assign res.count = iter_q;
	assign res.index = job_q.idx;

	always_comb begin
		state_n  = state_q;
		job_pop  = 1'b0;
		start_ab = 1'b0;
		start_c  = 1'b0;
		emit     = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (job_avail) begin
					job_pop = 1'b1;
					state_n = BK_MAP;
				end
			end
			BK_MAP: begin
				start_ab = 1'b1;
				state_n  = BK_MAP_WAIT;
			end
			BK_MAP_WAIT: begin
				if (map_done) begin
					state_n = BK_LOOP;
				end
			end
			BK_LOOP: begin
				if (iter_q < cfg.max_iter) begin
					start_ab = 1'b1;
					start_c  = 1'b1;
					state_n  = BK_SQ_WAIT;
				end else begin
					state_n = BK_EMIT;
				end
			end
			BK_SQ_WAIT: begin
				if (sq_done) begin
					state_n = BK_SUM;
				end
			end
			BK_SUM: begin
				state_n = BK_UPD;
			end
			BK_UPD: begin
				state_n = escape ? BK_EMIT : BK_LOOP;
			end
			BK_EMIT: begin
				if (slot_free) begin
					emit    = 1'b1;
					state_n = BK_IDLE;
				end
			end
			default: begin
				state_n = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			iter_q  <= '0;
		end else begin
			state_q <= state_n;
			if (state_q == BK_MAP_WAIT && map_done) begin
				iter_q <= '0;
			end else if (state_q == BK_UPD && !escape) begin
				iter_q <= iter_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_q <= job;
		end
		if (state_q == BK_MAP_WAIT && map_done) begin
			cr_q <= cr_n;
			ci_q <= ci_n;
			zr_q <= cr_n;
			zi_q <= ci_n;
		end
		if (state_q == BK_SUM) begin
			mag_q  <= pa + pb;
			diff_q <= $signed(pa - pb);
		end
		if (state_q == BK_UPD && !escape) begin
			zr_q <= zr_n;
			zi_q <= zi_n;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/mandelbrot_escape_time.sv =====
// ============================================================================
// Mandelbrot escape-time engine
// Each accepted pixel (pixel_x, pixel_y) inside the width x height region is
// mapped to c = (origin_x + pixel_x*step_x) + i*(origin_y - pixel_y*step_y) in
// signed Q8.56, then z = z^2 + c is iterated from z = c until |z|^2 reaches 4
// or the count reaches max_iterations; one result transfer carries that count
// and pixel_y*width + pixel_x. Pixels outside the region are dropped in the
// front end and give no result. Sides above 4096 act as 4096.
// The iteration engine works on one pixel at a time. Each iteration runs the
// three 64x64 multipliers, each built from one 32x32 multiplier stepping
// through four partial products, then the magnitude, update and loop steps. A
// two-entry queue sits between the front end and the engine, and the output
// register frees the engine while a result waits under res_stall. Registers
// are 64-bit at byte address 8*index; write them only while the block is idle.
// ============================================================================
`default_nettype none

`include "mandelbrot_escape_time_macros.svh"

module mandelbrot_escape_time (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mbrot_pkg::ADDR_W-1:0]  paddr,
	input  logic [mbrot_pkg::COORD_W-1:0] pwdata,
	output logic [mbrot_pkg::COORD_W-1:0] prdata,
	output logic                          pready,
	// pixel channel
	input  logic                          pix_valid,
	output logic                          pix_stall,
	input  logic [mbrot_pkg::PIX_W-1:0]   pixel_x,
	input  logic [mbrot_pkg::PIX_W-1:0]   pixel_y,
	// result channel
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic [mbrot_pkg::ITER_W-1:0]  iteration_count,
	output logic [mbrot_pkg::INDEX_W-1:0] pixel_index
);
	import mbrot_pkg::*;

	logic [COORD_W-1:0]   origin_x_q;
	logic [COORD_W-1:0]   origin_y_q;
	logic [COORD_W-1:0]   step_x_q;
	logic [COORD_W-1:0]   step_y_q;
	logic [SIDE_W-1:0]    width_q;
	logic [SIDE_W-1:0]    height_q;
	logic [ITER_W-1:0]    max_iter_q;
	logic                 cfg_wr;
	logic [REG_IDX_W-1:0] reg_idx;
	cfg_t                 cfg;

	logic                 q_push;
	logic                 q_full;
	logic                 q_pop;
	logic                 q_avail;
	job_t                 front_job;
	job_t                 head_job;

	logic                 emit;
	logic                 slot_free;
	res_t                 back_res;
	res_t                 res_q;
	logic                 res_valid_q;

	// ------------------------------------------------------------------------
	// Configuration registers: every access completes in its access cycle.
	// ------------------------------------------------------------------------
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[ADDR_W-1:REG_LSB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= ORIGIN_RST;
			origin_y_q <= ORIGIN_RST;
			step_x_q   <= STEP_RST;
			step_y_q   <= STEP_RST;
			width_q    <= SIDE_RST;
			height_q   <= SIDE_RST;
			max_iter_q <= MAX_ITER_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_ORIGIN_X: origin_x_q <= pwdata;
				REG_ORIGIN_Y: origin_y_q <= pwdata;
				REG_STEP_X:   step_x_q   <= pwdata;
				REG_STEP_Y:   step_y_q   <= pwdata;
				REG_WIDTH:    width_q    <= pwdata[SIDE_W-1:0];
				REG_HEIGHT:   height_q   <= pwdata[SIDE_W-1:0];
				REG_MAX_ITER: max_iter_q <= pwdata[ITER_W-1:0];
				default: begin
					// drop writes beyond the register list
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_ORIGIN_X: prdata = origin_x_q;
			REG_ORIGIN_Y: prdata = origin_y_q;
			REG_STEP_X:   prdata = step_x_q;
			REG_STEP_Y:   prdata = step_y_q;
			REG_WIDTH:    prdata = COORD_W'(width_q);
			REG_HEIGHT:   prdata = COORD_W'(height_q);
			REG_MAX_ITER: prdata = COORD_W'(max_iter_q);
			default:      prdata = '0;
		endcase
	end

	assign cfg.origin_x = origin_x_q;
	assign cfg.origin_y = origin_y_q;
	assign cfg.step_x   = step_x_q;
	assign cfg.step_y   = step_y_q;
	assign cfg.width    = width_q;
	assign cfg.height   = height_q;
	assign cfg.max_iter = max_iter_q;

	// ------------------------------------------------------------------------
	// Front end: bounds check and index, then into the job queue.
	// ------------------------------------------------------------------------
	mbrot_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.cfg       (cfg),
		.q_full    (q_full),
		.push      (q_push),
		.job       (front_job)
	);

	mbrot_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (front_job),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (head_job),
		.avail     (q_avail)
	);

	// ------------------------------------------------------------------------
	// Iteration engine: one job at a time.
	// ------------------------------------------------------------------------
	mbrot_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.job       (head_job),
		.job_avail (q_avail),
		.job_pop   (q_pop),
		.slot_free (slot_free),
		.emit      (emit),
		.res       (back_res)
	);

	// ------------------------------------------------------------------------
	// Output register: load when empty or when the waiting result transfers.
	// ------------------------------------------------------------------------
	assign slot_free = !res_valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= back_res;
		end
	end

	assign res_valid       = res_valid_q;
	assign iteration_count = res_q.count;
	assign pixel_index     = res_q.index;

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------
	`MBROT_ASSERT_IMP(a_emit_slot, emit, slot_free, "engine emitted into a full output register")
	`MBROT_ASSERT_IMP(a_pop_avail, q_pop, q_avail, "engine popped an empty job queue")
	`MBROT_ASSERT_IMP(a_res_rise, $rose(res_valid_q), $past(emit), "result appeared without emit")
	`MBROT_ASSERT_NXT(a_max_iter_wr, cfg_wr && (reg_idx == REG_MAX_ITER), max_iter_q == $past(pwdata[ITER_W-1:0]), "iteration limit write lost")

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// Mandelbrot escape-time engine testbench
// Sends pixel coordinates over the valid/stall pixel channel and checks each
// result transfer against an in-bench Q8.56 escape-time predictor. Registers
// are written over the APB-style port between phases, with the engine idle.
// Both channels idle and stall in random bursts, except in one view midway and the last.
// ============================================================================

module tb;
	import mbrot_pkg::*;

	// 1.0 in signed Q8.56
	localparam longint ONE = 64'sh0100_0000_0000_0000;
	// ends of the signed 64-bit coordinate range
	localparam logic [COORD_W-1:0] Q_TOP    = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [COORD_W-1:0] Q_BOTTOM = 64'h8000_0000_0000_0000;
	// |z|^2 escape bound, 4.0 at twice the fraction bits
	localparam logic [PROD_W-1:0] ESCAPE_BOUND = 128'd4 << (2 * FRAC_BITS);
	// register slot past the end of the map; writes to it must be ignored
	localparam logic [REG_IDX_W-1:0] REG_SPARE = 3'd7;
	// cycles to let pass once the last result is in, so that a dropped
	// pixel still sitting in the front end has left before a register write
	localparam int SETTLE_CYCLES = 40;
	// slowest pixel in this run needs 256 iterations plus mapping and emit,
	// and this limit lies well beyond the time that takes
	localparam int QUIET_LIMIT = 20000;
	localparam int ITEMS_PER_VIEW = 82;
	localparam int VIEW_COUNT = 10;

	typedef struct packed {
		logic [ITER_W-1:0]  count;
		logic [INDEX_W-1:0] index;
	} pixel_result_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 psel      = 1'b0;
	logic                 penable   = 1'b0;
	logic                 pwrite    = 1'b0;
	logic [ADDR_W-1:0]    paddr     = '0;
	logic [COORD_W-1:0]   pwdata    = '0;
	logic [COORD_W-1:0]   prdata;
	logic                 pready;
	logic                 pix_valid = 1'b0;
	logic                 pix_stall;
	logic [PIX_W-1:0]     pixel_x   = '0;
	logic [PIX_W-1:0]     pixel_y   = '0;
	logic                 res_valid;
	logic                 res_stall = 1'b0;
	logic [ITER_W-1:0]    iteration_count;
	logic [INDEX_W-1:0]   pixel_index;

	// shadow of the register file, kept in step with every write
	cfg_t view;
	// results owed by the engine, oldest first
	pixel_result_t awaited[$];
	int mismatch_count = 0;
	int quiet_cycles = 0;
	int stall_left = 0;
	// random idling on both channels; cleared for quiet stretches
	bit idle_on = 1'b1;

	mandelbrot_escape_time uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.pix_valid       (pix_valid),
		.pix_stall       (pix_stall),
		.pixel_x         (pixel_x),
		.pixel_y         (pixel_y),
		.res_valid       (res_valid),
		.res_stall       (res_stall),
		.iteration_count (iteration_count),
		.pixel_index     (pixel_index)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Escape-time predictor
	// ------------------------------------------------------------------------

	// sign-extend a Q8.56 pattern to the exact product width
	function automatic logic signed [PROD_W-1:0] widen_q(input logic [COORD_W-1:0] v);
		return PROD_W'($signed(v));
	endfunction

	// clip a wide sum back into the signed 64-bit range
	function automatic logic [COORD_W-1:0] clamp_q(input logic signed [PROD_W-1:0] v);
		if (v > widen_q(Q_TOP)) begin
			return Q_TOP;
		end else if (v < widen_q(Q_BOTTOM)) begin
			return Q_BOTTOM;
		end
		return v[COORD_W-1:0];
	endfunction

	// Returns 1 and fills res when the pixel lies inside the region.
	function automatic bit escape_time(input cfg_t cfg, input logic [PIX_W-1:0] px,
			input logic [PIX_W-1:0] py, output pixel_result_t res);
		int unsigned w;
		int unsigned h;
		int unsigned n;
		logic signed [PROD_W-1:0] sr;
		logic signed [PROD_W-1:0] si;
		logic [PROD_W-1:0] mag;
		logic [COORD_W-1:0] cr;
		logic [COORD_W-1:0] ci;
		logic [COORD_W-1:0] zr;
		logic [COORD_W-1:0] zi;
		logic [COORD_W-1:0] nr;
		res = '0;
		// oversized sides act as the largest side
		w = (cfg.width > MAX_SIDE) ? MAX_SIDE : cfg.width;
		h = (cfg.height > MAX_SIDE) ? MAX_SIDE : cfg.height;
		if (px >= w || py >= h) begin
			return 1'b0;
		end
		cr = clamp_q(widen_q(cfg.origin_x) + widen_q({52'd0, px}) * widen_q(cfg.step_x));
		ci = clamp_q(widen_q(cfg.origin_y) - widen_q({52'd0, py}) * widen_q(cfg.step_y));
		zr = cr;
		zi = ci;
		n = 0;
		while (n < cfg.max_iter) begin
			sr = widen_q(zr) * widen_q(zr);
			si = widen_q(zi) * widen_q(zi);
			// both squares are non-negative; their sum can reach 2^127, so
			// compare it unsigned
			mag = sr + si;
			if (mag >= ESCAPE_BOUND) begin
				break;
			end
			// rescale rounds toward minus infinity; the cross term is doubled
			// by shifting one place less
			nr = clamp_q(((sr - si) >>> FRAC_BITS) + widen_q(cr));
			zi = clamp_q(((widen_q(zr) * widen_q(zi)) >>> (FRAC_BITS - 1)) + widen_q(ci));
			zr = nr;
			n++;
		end
		res.count = n[ITER_W-1:0];
		res.index = INDEX_W'(py * w + px);
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------------
	// Channel and register drivers
	// ------------------------------------------------------------------------

	// Send one pixel transfer and book its result, if any, once accepted.
	// Valid is left high so the next pixel can follow back to back.
	task automatic send_pixel(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y);
		pixel_result_t res;
		@(negedge clk);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			pix_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		pix_valid <= 1'b1;
		pixel_x <= x;
		pixel_y <= y;
		do @(posedge clk); while (pix_stall);
		if (escape_time(view, x, y, res)) begin
			awaited.push_back(res);
		end
	endtask

	// Drop valid, wait for every owed result, then let the front end go quiet.
	task automatic settle_idle();
		@(negedge clk);
		pix_valid <= 1'b0;
		while (awaited.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle until pready.
	task automatic write_register(input logic [REG_IDX_W-1:0] idx,
			input logic [COORD_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(idx) << REG_LSB;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		// narrow registers keep only their low bits
		case (idx)
			REG_ORIGIN_X: view.origin_x = value;
			REG_ORIGIN_Y: view.origin_y = value;
			REG_STEP_X:   view.step_x = value;
			REG_STEP_Y:   view.step_y = value;
			REG_WIDTH:    view.width = value[SIDE_W-1:0];
			REG_HEIGHT:   view.height = value[SIDE_W-1:0];
			REG_MAX_ITER: view.max_iter = value[ITER_W-1:0];
			default: ;
		endcase
	endtask

	// Program the whole register file. Narrow registers get junk above their
	// width, which the block must discard.
	task automatic set_view(input logic [COORD_W-1:0] ox, oy, sx, sy,
			input int unsigned w, h, n);
		logic [COORD_W-1:0] junk;
		junk = {$urandom, $urandom};
		write_register(REG_ORIGIN_X, ox);
		write_register(REG_ORIGIN_Y, oy);
		write_register(REG_STEP_X, sx);
		write_register(REG_STEP_Y, sy);
		write_register(REG_WIDTH, (junk & ~64'h1FFF) | 64'(w[SIDE_W-1:0]));
		write_register(REG_HEIGHT, (junk & ~64'h1FFF) | 64'(h[SIDE_W-1:0]));
		write_register(REG_MAX_ITER, (junk & ~64'hFFFF) | 64'(n[ITER_W-1:0]));
	endtask

	// ------------------------------------------------------------------------
	// Result side: random stall bursts, checking, watchdog
	// ------------------------------------------------------------------------

	// Hold stall in random bursts while idling is on.
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			res_stall <= 1'b1;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(0, 16);
			res_stall <= 1'b1;
		end else begin
			res_stall <= 1'b0;
		end
	end

	// Compare each result transfer with the oldest owed result.
	always @(posedge clk) begin : check_results
		pixel_result_t head;
		if (arst_n && res_valid && !res_stall) begin
			if (awaited.size() == 0) begin
				$display("%0t: result with none owed: count %0d index %0d",
					$time, iteration_count, pixel_index);
				mismatch_count++;
			end else begin
				head = awaited.pop_front();
				if (iteration_count !== head.count || pixel_index !== head.index) begin
					$display("%0t: expected count %0d index %0d, actual count %0d index %0d",
						$time, head.count, head.index, iteration_count, pixel_index);
					mismatch_count++;
				end
			end
		end
	end

	// End the run if no transfer moves on either channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (pix_valid && !pix_stall) || (res_valid && !res_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("%0t: no transfer for %0d cycles, %0d results owed",
				$time, QUIET_LIMIT, awaited.size());
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Reset values: c = 0 everywhere, so every pixel in the 1024 x 1024
	// region runs to the full 256 iterations.
	task automatic test_reset_defaults();
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd1023, 12'd1023);
		send_pixel(12'd1024, 12'd0);
		send_pixel(12'd0, 12'd1024);
		send_pixel(12'd4095, 12'd4095);
		settle_idle();
	endtask

	// Region bounds: oversized width, empty region, a single pixel.
	task automatic test_region_edges();
		// width of all ones clips to 4096; the far corner gives the top index
		set_view(-2 * ONE, ONE, ONE >>> 10, ONE >>> 10, 8191, MAX_SIDE, 3);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd0);
		send_pixel(12'd0, 12'd4095);
		settle_idle();
		// empty region: nothing comes back
		write_register(REG_WIDTH, 64'd0);
		send_pixel(12'd0, 12'd0);
		settle_idle();
		write_register(REG_WIDTH, 64'd1);
		write_register(REG_HEIGHT, 64'd1);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd1, 12'd0);
		send_pixel(12'd0, 12'd1);
		settle_idle();
	endtask

	// Iteration limit of zero, one and the largest value.
	task automatic test_iteration_limits();
		set_view(64'd0, 64'd0, 64'd0, 64'd0, 16, 16, 0);
		send_pixel(12'd3, 12'd3);
		settle_idle();
		write_register(REG_MAX_ITER, 64'd1);
		send_pixel(12'd15, 12'd15);
		settle_idle();
		// c = 2 sits exactly on the escape bound; c = 0.5 escapes in a few
		// steps, so the large limit is never reached
		set_view(2 * ONE, 64'd0, 64'd0, 64'd0, 16, 16, 65535);
		send_pixel(12'd0, 12'd0);
		settle_idle();
		write_register(REG_ORIGIN_X, ONE / 2);
		send_pixel(12'd1, 12'd1);
		settle_idle();
	endtask

	// Mapping sums that leave the 64-bit range must clip to its ends.
	task automatic test_coordinate_saturation();
		// origin at the bottom corner: |c|^2 is 2^127 at pixel zero
		set_view(Q_BOTTOM, Q_BOTTOM, Q_TOP, Q_TOP, MAX_SIDE, MAX_SIDE, 4);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd0, 12'd0);
		settle_idle();
		set_view(Q_TOP, Q_TOP, Q_BOTTOM, Q_BOTTOM, MAX_SIDE, MAX_SIDE, 4);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd0, 12'd0);
		settle_idle();
	endtask

	// A write past the register map changes nothing.
	task automatic test_unknown_register();
		set_view(-2 * ONE, ONE, ONE / 4, ONE / 4, 8, 8, 20);
		write_register(REG_SPARE, {$urandom, $urandom});
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd5, 12'd3);
		settle_idle();
	endtask

	// Random views: mostly windows onto the set at random zoom, some wholly
	// random register contents. Most pixels land inside the region.
	task automatic test_random_views();
		int unsigned w;
		int unsigned h;
		int unsigned eff_w;
		int unsigned eff_h;
		int unsigned n;
		int unsigned zoom;
		longint sx;
		longint sy;
		longint cx;
		longint cy;
		for (int v = 0; v < VIEW_COUNT; v++) begin
			// one quiet stretch midway, and the closing view without idling
			idle_on = (v != VIEW_COUNT / 2) && (v != VIEW_COUNT - 1);
			case ($urandom_range(0, 9))
				0: w = MAX_SIDE;
				1: w = $urandom_range(MAX_SIDE + 1, 8191);
				default: w = $urandom_range(1, 64);
			endcase
			case ($urandom_range(0, 9))
				0: h = MAX_SIDE;
				1: h = $urandom_range(MAX_SIDE + 1, 8191);
				default: h = $urandom_range(1, 64);
			endcase
			eff_w = (w > MAX_SIDE) ? MAX_SIDE : w;
			eff_h = (h > MAX_SIDE) ? MAX_SIDE : h;
			if ($urandom_range(0, 7) == 0) begin
				n = $urandom_range(0, 160);
			end else begin
				n = $urandom_range(0, 40);
			end
			if ($urandom_range(0, 4) == 0) begin
				set_view({$urandom, $urandom}, {$urandom, $urandom},
					{$urandom, $urandom}, {$urandom, $urandom}, w, h, n);
			end else begin
				// window three units wide, narrowed by a random zoom, centered on a point near the set
				zoom = $urandom_range(0, 8);
				sx = (ONE * 3 / longint'(eff_w)) >>> zoom;
				sy = (ONE * 3 / longint'(eff_h)) >>> zoom;
				if ($urandom_range(0, 5) == 0) begin
					sx = -sx;
				end
				if ($urandom_range(0, 5) == 0) begin
					sy = -sy;
				end
				cx = -2 * ONE + longint'($urandom_range(0, 2500)) * (ONE / 1000);
				cy = -(ONE * 6 / 5) + longint'($urandom_range(0, 2400)) * (ONE / 1000);
				set_view(cx - longint'(eff_w / 2) * sx, cy + longint'(eff_h / 2) * sy,
					sx, sy, w, h, n);
			end
			for (int k = 0; k < ITEMS_PER_VIEW; k++) begin
				if ($urandom_range(0, 9) != 0) begin
					send_pixel(PIX_W'($urandom_range(0, eff_w - 1)),
						PIX_W'($urandom_range(0, eff_h - 1)));
				end else begin
					send_pixel(PIX_W'($urandom), PIX_W'($urandom));
				end
			end
			settle_idle();
		end
	endtask

	initial begin
		view.origin_x = ORIGIN_RST;
		view.origin_y = ORIGIN_RST;
		view.step_x = STEP_RST;
		view.step_y = STEP_RST;
		view.width = SIDE_RST;
		view.height = SIDE_RST;
		view.max_iter = MAX_ITER_RST;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_region_edges();
		test_iteration_limits();
		test_coordinate_saturation();
		test_unknown_register();
		test_random_views();
		// drain whatever is still owed, then watch for stray results
		while (awaited.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
